/* hw/rtl/multipart_boundary_scanner_unit_defines.svh */
// Assertion helpers for the checker file of this block.
`ifndef MULTIPART_BOUNDARY_SCANNER_UNIT_DEFINES_SVH
`define MULTIPART_BOUNDARY_SCANNER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MBS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/mbs_pkg.sv */
`timescale 1ns / 1ps

package mbs_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned PRE_W   = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PADDR_W = 3;

  localparam logic [BYTE_W-1:0] CH_DASH = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;

  localparam logic [PRE_W-1:0] PRE_CR      = 3'd1;
  localparam logic [PRE_W-1:0] PRE_CRLF    = 3'd2;
  localparam logic [PRE_W-1:0] PRE_CRLFD   = 3'd3;
  localparam logic [PRE_W-1:0] PRE_FULL    = 3'd4;

  localparam logic CFG_IDX_BOUNDARY_LENGTH = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_BODY  = 2'd2
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_HDR  = 3'd0,
    KIND_LINE = 3'd1,
    KIND_DATA = 3'd2,
    KIND_PART = 3'd3,
    KIND_DONE = 3'd4,
    KIND_ERR  = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    SCAN_OPEN    = 4'd0,
    SCAN_HEADERS = 4'd1,
    SCAN_DATA    = 4'd2,
    SCAN_FEED1   = 4'd3,
    SCAN_DASH1   = 4'd4,
    SCAN_DASH2   = 4'd5,
    SCAN_MATCH   = 4'd6,
    SCAN_AFTER   = 4'd7,
    SCAN_FEED2   = 4'd8,
    SCAN_DONE    = 4'd9,
    SCAN_ERROR   = 4'd10
  } scan_e;

  typedef enum logic [1:0] {
    CTRL_IDLE   = 2'd0,
    CTRL_DECIDE = 2'd1,
    CTRL_EMIT   = 2'd2
  } ctrl_state_e;

  typedef enum logic [1:0] {
    SRC_PREFIX = 2'd0,
    SRC_REPLAY = 2'd1,
    SRC_CR     = 2'd2,
    SRC_FINAL  = 2'd3
  } emit_src_e;

  typedef struct packed {
    logic              has_out;
    logic [PRE_W-1:0]  pre_cnt;
    logic [LEN_W-1:0]  rep_cnt;
    logic              tail_cr;
    kind_e             fin_kind;
    logic [BYTE_W-1:0] fin_byte;
  } plan_t;

  typedef struct packed {
    logic      idle;
    logic      decide;
    logic      emit_load;
    emit_src_e emit_src;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_out;
    logic pre_more;
    logic rep_more;
    logic cr_more;
    logic slot_free;
  } ctrl_status_t;

  function automatic logic [BYTE_W-1:0] prefix_byte(input logic [1:0] pos);
    logic [BYTE_W-1:0] b;
    case (pos)
      2'd0:    b = CH_CR;
      2'd1:    b = CH_LF;
      default: b = CH_DASH;
    endcase
    return b;
  endfunction

  function automatic plan_t make_plan(input logic [PRE_W-1:0] pre_cnt,
                                      input logic [LEN_W-1:0] rep_cnt,
                                      input logic tail_cr,
                                      input kind_e kind,
                                      input logic [BYTE_W-1:0] b);
    plan_t p;
    p.has_out  = 1'b1;
    p.pre_cnt  = pre_cnt;
    p.rep_cnt  = rep_cnt;
    p.tail_cr  = tail_cr;
    p.fin_kind = kind;
    p.fin_byte = (kind == KIND_HDR || kind == KIND_DATA) ? b : '0;
    return p;
  endfunction

endpackage

/* hw/rtl/mbs_channel_if.sv */
`timescale 1ns / 1ps

interface mbs_in_if;
  import mbs_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] byte_value;
  logic [LEN_W-1:0]  boundary_index;

  modport source (output valid, op, byte_value, boundary_index, input ready);
  modport sink   (input valid, op, byte_value, boundary_index, output ready);
endinterface

interface mbs_out_if;
  import mbs_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;

  modport source (output valid, kind, out_byte, last_of_run, input ready);
  modport sink   (input valid, kind, out_byte, last_of_run, output ready);
endinterface

/* hw/rtl/mbs_datapath.sv */
`timescale 1ns / 1ps

module mbs_datapath #(
  parameter int unsigned MAX_BOUNDARY = 48
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mbs_pkg::ctrl_cmd_t           cmd_i,
  output mbs_pkg::ctrl_status_t        status_o,
  input  logic [mbs_pkg::LEN_W-1:0]    cfg_len_i,
  input  logic [mbs_pkg::OP_W-1:0]     op_i,
  input  logic [mbs_pkg::BYTE_W-1:0]   byte_value_i,
  input  logic [mbs_pkg::LEN_W-1:0]    boundary_index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mbs_pkg::KIND_W-1:0]   out_kind_o,
  output logic [mbs_pkg::BYTE_W-1:0]   out_byte_o,
  output logic                         out_last_o
);
  import mbs_pkg::*;

  localparam int unsigned AW = (MAX_BOUNDARY > 1) ? $clog2(MAX_BOUNDARY) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BOUNDARY);

  logic [BYTE_W-1:0] bnd_mem_q [MAX_BOUNDARY];
  logic [BYTE_W-1:0] rdata_q;
  logic [AW-1:0]     rd_addr;

  logic [OP_W-1:0]   op_q;
  logic [BYTE_W-1:0] byte_q;
  logic [LEN_W-1:0]  idx_q;

  scan_e            scan_q, scan_d;
  logic [LEN_W-1:0] opos_q, opos_d;
  logic [LEN_W-1:0] mpos_q, mpos_d;
  logic             lht_q, lht_d;

  plan_t plan_q, plan_d;

  logic [PRE_W-1:0] pre_idx_q, pre_idx_d;
  logic [LEN_W-1:0] rep_idx_q, rep_idx_d;
  logic             cr_done_q, cr_done_d;

  logic              out_valid_q;
  logic [KIND_W-1:0] out_kind_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last_q;

  logic [LEN_W-1:0] len_eff;
  logic [LEN_W:0]   p_ext;
  logic [LEN_W:0]   l_ext;
  logic [LEN_W-1:0] lookup;
  logic             slot_free;

  function automatic logic [AW-1:0] clamp_addr(input logic [LEN_W-1:0] v);
    return (v < MAX_LEN) ? v[AW-1:0] : '0;
  endfunction

  assign len_eff = (cfg_len_i == '0) ? LEN_W'(1) :
                   (cfg_len_i > MAX_LEN) ? MAX_LEN : cfg_len_i;
  assign p_ext   = {1'b0, opos_q};
  assign l_ext   = {1'b0, len_eff};

  assign lookup  = (scan_q == SCAN_MATCH) ? mpos_q : (opos_q - LEN_W'(2));
  assign rd_addr = cmd_i.idle ? clamp_addr(lookup) : clamp_addr(rep_idx_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide && op_q == OP_LOAD && idx_q < MAX_LEN) begin
      bnd_mem_q[clamp_addr(idx_q)] <= byte_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= bnd_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.idle) begin
      op_q   <= op_i;
      byte_q <= byte_value_i;
      idx_q  <= boundary_index_i;
    end
    if (cmd_i.decide) begin
      plan_q <= plan_d;
    end
  end

  always_comb begin
    scan_d = scan_q;
    opos_d = opos_q;
    mpos_d = mpos_q;
    lht_d  = lht_q;
    plan_d = '0;
    plan_d.fin_kind = KIND_DATA;
    unique case (op_q)
      OP_START: begin
        scan_d = SCAN_OPEN;
        opos_d = '0;
        mpos_d = '0;
        lht_d  = 1'b0;
      end
      OP_BODY: begin
        unique case (scan_q)
          SCAN_OPEN: begin
            if (opos_q < LEN_W'(2)) begin
              if (byte_q != CH_DASH) begin
                scan_d = SCAN_ERROR;
                plan_d = make_plan('0, '0, 1'b0, KIND_ERR, '0);
              end else begin
                opos_d = opos_q + LEN_W'(1);
              end
            end else if (p_ext < l_ext + (LEN_W+1)'(2)) begin
              if (byte_q != rdata_q) begin
                scan_d = SCAN_ERROR;
                plan_d = make_plan('0, '0, 1'b0, KIND_ERR, '0);
              end else begin
                opos_d = opos_q + LEN_W'(1);
              end
            end else if (p_ext == l_ext + (LEN_W+1)'(2)) begin
              if (byte_q != CH_CR) begin
                scan_d = SCAN_ERROR;
                plan_d = make_plan('0, '0, 1'b0, KIND_ERR, '0);
              end else begin
                opos_d = opos_q + LEN_W'(1);
              end
            end else if (p_ext == l_ext + (LEN_W+1)'(3)) begin
              if (byte_q != CH_LF) begin
                scan_d = SCAN_ERROR;
                plan_d = make_plan('0, '0, 1'b0, KIND_ERR, '0);
              end else begin
                scan_d = SCAN_HEADERS;
                lht_d  = 1'b0;
              end
            end else begin
              scan_d = SCAN_ERROR;
              plan_d = make_plan('0, '0, 1'b0, KIND_ERR, '0);
            end
          end
          SCAN_HEADERS: begin
            if (byte_q == CH_LF) begin
              if (lht_q) begin
                plan_d = make_plan('0, '0, 1'b0, KIND_LINE, '0);
                lht_d  = 1'b0;
              end else begin
                scan_d = SCAN_DATA;
              end
            end else if (byte_q != CH_CR) begin
              plan_d = make_plan('0, '0, 1'b0, KIND_HDR, byte_q);
              lht_d  = 1'b1;
            end
          end
          SCAN_DATA: begin
            if (byte_q == CH_CR) begin
              scan_d = SCAN_FEED1;
            end else begin
              plan_d = make_plan('0, '0, 1'b0, KIND_DATA, byte_q);
            end
          end
          SCAN_FEED1: begin
            if (byte_q == CH_LF) begin
              scan_d = SCAN_DASH1;
            end else begin
              scan_d = SCAN_DATA;
              plan_d = make_plan(PRE_CR, '0, 1'b0, KIND_DATA, byte_q);
            end
          end
          SCAN_DASH1: begin
            if (byte_q == CH_DASH) begin
              scan_d = SCAN_DASH2;
            end else begin
              scan_d = SCAN_DATA;
              plan_d = make_plan(PRE_CRLF, '0, 1'b0, KIND_DATA, byte_q);
            end
          end
          SCAN_DASH2: begin
            if (byte_q == CH_DASH) begin
              scan_d = SCAN_MATCH;
              mpos_d = '0;
            end else begin
              scan_d = SCAN_DATA;
              plan_d = make_plan(PRE_CRLFD, '0, 1'b0, KIND_DATA, byte_q);
            end
          end
          SCAN_MATCH: begin
            if (mpos_q >= len_eff) begin
              scan_d = SCAN_AFTER;
              plan_d = make_plan('0, '0, 1'b0, KIND_PART, '0);
            end else if (rdata_q != byte_q) begin
              scan_d = SCAN_DATA;
              plan_d = make_plan(PRE_FULL, mpos_q, 1'b0, KIND_DATA, byte_q);
            end else if (mpos_q == len_eff - LEN_W'(1)) begin
              scan_d = SCAN_AFTER;
              plan_d = make_plan('0, '0, 1'b0, KIND_PART, '0);
            end else begin
              mpos_d = mpos_q + LEN_W'(1);
            end
          end
          SCAN_AFTER: begin
            if (byte_q == CH_CR) begin
              scan_d = SCAN_FEED2;
            end else if (byte_q == CH_DASH) begin
              scan_d = SCAN_DONE;
              plan_d = make_plan('0, '0, 1'b0, KIND_DONE, '0);
            end else begin
              scan_d = SCAN_DATA;
              plan_d = make_plan(PRE_FULL, len_eff, 1'b0, KIND_DATA, byte_q);
            end
          end
          SCAN_FEED2: begin
            if (byte_q == CH_LF) begin
              scan_d = SCAN_HEADERS;
              lht_d  = 1'b0;
            end else begin
              scan_d = SCAN_DATA;
              plan_d = make_plan(PRE_FULL, len_eff, 1'b1, KIND_DATA, byte_q);
            end
          end
          SCAN_DONE: begin
          end
          default: begin
            scan_d = SCAN_ERROR;
            plan_d = make_plan('0, '0, 1'b0, KIND_ERR, '0);
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= SCAN_OPEN;
      opos_q <= '0;
      mpos_q <= '0;
      lht_q  <= 1'b0;
    end else if (cmd_i.decide) begin
      scan_q <= scan_d;
      opos_q <= opos_d;
      mpos_q <= mpos_d;
      lht_q  <= lht_d;
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    pre_idx_d = pre_idx_q;
    rep_idx_d = rep_idx_q;
    cr_done_d = cr_done_q;
    if (cmd_i.decide) begin
      pre_idx_d = '0;
      rep_idx_d = '0;
      cr_done_d = 1'b0;
    end else if (cmd_i.emit_load) begin
      case (cmd_i.emit_src)
        SRC_PREFIX: pre_idx_d = pre_idx_q + PRE_W'(1);
        SRC_REPLAY: rep_idx_d = rep_idx_q + LEN_W'(1);
        SRC_CR:     cr_done_d = 1'b1;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_idx_q <= '0;
      rep_idx_q <= '0;
      cr_done_q <= 1'b0;
    end else begin
      pre_idx_q <= pre_idx_d;
      rep_idx_q <= rep_idx_d;
      cr_done_q <= cr_done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      case (cmd_i.emit_src)
        SRC_PREFIX: begin
          out_kind_q <= KIND_DATA;
          out_byte_q <= prefix_byte(pre_idx_q[1:0]);
          out_last_q <= 1'b0;
        end
        SRC_REPLAY: begin
          out_kind_q <= KIND_DATA;
          out_byte_q <= rdata_q;
          out_last_q <= 1'b0;
        end
        SRC_CR: begin
          out_kind_q <= KIND_DATA;
          out_byte_q <= CH_CR;
          out_last_q <= 1'b0;
        end
        default: begin
          out_kind_q <= plan_q.fin_kind;
          out_byte_q <= plan_q.fin_byte;
          out_last_q <= 1'b1;
        end
      endcase
    end
  end

  assign status_o.has_out   = plan_q.has_out;
  assign status_o.pre_more  = pre_idx_q < plan_q.pre_cnt;
  assign status_o.rep_more  = rep_idx_q < plan_q.rep_cnt;
  assign status_o.cr_more   = plan_q.tail_cr && !cr_done_q;
  assign status_o.slot_free = slot_free;

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

/* hw/rtl/mbs_ctrl.sv */
`timescale 1ns / 1ps

module mbs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  mbs_pkg::ctrl_status_t status_i,
  output mbs_pkg::ctrl_cmd_t    cmd_o
);
  import mbs_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o.idle     = 1'b0;
    cmd_o.decide   = 1'b0;
    cmd_o.emit_load = 1'b0;
    cmd_o.emit_src = SRC_FINAL;
    unique case (state_q)
      CTRL_IDLE: begin
        cmd_o.idle = 1'b1;
        if (in_valid_i) begin
          state_d = CTRL_DECIDE;
        end
      end
      CTRL_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = CTRL_EMIT;
      end
      CTRL_EMIT: begin
        if (status_i.pre_more) begin
          cmd_o.emit_src = SRC_PREFIX;
        end else if (status_i.rep_more) begin
          cmd_o.emit_src = SRC_REPLAY;
        end else if (status_i.cr_more) begin
          cmd_o.emit_src = SRC_CR;
        end else begin
          cmd_o.emit_src = SRC_FINAL;
        end
        if (!status_i.has_out) begin
          state_d = CTRL_IDLE;
        end else if (status_i.slot_free) begin
          cmd_o.emit_load = 1'b1;
          if (cmd_o.emit_src == SRC_FINAL) begin
            state_d = CTRL_IDLE;
          end
        end
      end
      default: begin
        state_d = CTRL_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/multipart_boundary_scanner_unit.sv */
`timescale 1ns / 1ps
// Channel  Role    Carries
// in_i     sink    op, byte_value, boundary_index
// out_o    source  kind, out_byte, last_of_run
// APB      slave   boundary_length at byte address 0
//
// An item is taken in the idle state; the next one is taken once the controller has passed through its
// decide and emit states and has loaded every result of the item into the output register.
// This pacing is set by the single read port of the boundary store and by the output
// register, which takes one result per cycle while the output is not stalled.
// Reset clears the scan state and the length register to 1; the boundary store is not cleared.
// A stalled output holds its result and pauses the emission until the sink takes it.

module multipart_boundary_scanner_unit #(
  parameter int unsigned MAX_BOUNDARY = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mbs_in_if.sink                        in_i,
  mbs_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbs_pkg::PADDR_W-1:0]   paddr,
  input  logic [mbs_pkg::DATA_W-1:0]    pwdata,
  output logic [mbs_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import mbs_pkg::*;

  logic [LEN_W-1:0] len_q;
  logic             cfg_we;
  ctrl_cmd_t        cmd;
  ctrl_status_t     status;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[PADDR_W-1] == CFG_IDX_BOUNDARY_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_W'(1);
    end else if (cfg_we) begin
      len_q <= pwdata[LEN_W-1:0];
    end
  end

  assign prdata = (paddr[PADDR_W-1] == CFG_IDX_BOUNDARY_LENGTH) ? DATA_W'(len_q) : '0;

  assign in_i.ready = cmd.idle;

  mbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mbs_datapath #(
    .MAX_BOUNDARY (MAX_BOUNDARY)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_len_i        (len_q),
    .op_i             (in_i.op),
    .byte_value_i     (in_i.byte_value),
    .boundary_index_i (in_i.boundary_index),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .out_kind_o       (out_o.kind),
    .out_byte_o       (out_o.out_byte),
    .out_last_o       (out_o.last_of_run)
  );

endmodule

/* hw/rtl/mbs_checker.sv */
`timescale 1ns / 1ps
`include "multipart_boundary_scanner_unit_defines.svh"

module mbs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [mbs_pkg::KIND_W-1:0]  out_kind_i,
  input logic [mbs_pkg::BYTE_W-1:0]  out_byte_i,
  input logic                        out_last_i,
  input logic                        psel_i,
  input logic                        penable_i,
  input logic                        pwrite_i,
  input logic [mbs_pkg::PADDR_W-1:0] paddr_i,
  input logic [mbs_pkg::DATA_W-1:0]  pwdata_i,
  input logic [mbs_pkg::DATA_W-1:0]  prdata_i
);
  import mbs_pkg::*;

  // A result waiting at the output holds still until it is taken.
  `MBS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_kind_i) && $stable(out_byte_i) && $stable(out_last_i), "output item changed while stalled")

  // Only header and data bytes carry a byte value.
  `MBS_ASSERT_NOW(a_byte_zero, clk_i, rst_ni, out_valid_i && out_kind_i != KIND_HDR && out_kind_i != KIND_DATA, out_byte_i == '0, "marker item carries a nonzero byte")

  // Results of one item follow each other without a gap.
  `MBS_ASSERT_NXT(a_run_dense, clk_i, rst_ni, out_valid_i && out_ready_i && !out_last_i, out_valid_i, "gap inside a run of results")

  // The scanner works on one item at a time.
  `MBS_ASSERT_NXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "item taken while another is in work")

  // A length write reads back on the next cycle.
  `MBS_ASSERT_NXT(a_cfg_readback, clk_i, rst_ni, psel_i && penable_i && pwrite_i && paddr_i[PADDR_W-1] == CFG_IDX_BOUNDARY_LENGTH, paddr_i[PADDR_W-1] != CFG_IDX_BOUNDARY_LENGTH || prdata_i[LEN_W-1:0] == $past(pwdata_i[LEN_W-1:0]), "length register did not take the write")

endmodule

bind multipart_boundary_scanner_unit mbs_checker u_mbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.kind),
  .out_byte_i  (out_o.out_byte),
  .out_last_i  (out_o.last_of_run),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);
